// ===== rtl/lru_order_tracker_top_defines.svh =====
// Assertion macros for the LRU order tracker RTL, used by lru_ot_list.
// No dependencies; included inside module bodies that declare i_clk and i_rst_n.
`ifndef LRU_ORDER_TRACKER_TOP_DEFINES_SVH
`define LRU_ORDER_TRACKER_TOP_DEFINES_SVH

// Clocked check, switched off while the synchronous reset is asserted
`define LOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define LOT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/lru_ot_pkg.sv =====
// Shared types and constants for the LRU order tracker.
// No dependencies; imported by lru_ot_list and lru_order_tracker_top.
package lru_ot_pkg;

    // Number of tracked entries; the entry number field spans all of them
    localparam int ENTRIES = 64;
    localparam int ENTRY_W = $clog2(ENTRIES);

    typedef logic [ENTRY_W-1:0] t_entry;

    typedef enum logic [1:0] {
        ACT_TOUCH   = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_RECLAIM = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    // One request as held in the input register
    typedef struct packed {
        t_action action;
        t_entry  entry_id;
        logic    keep_given;
    } t_req;

    // One result as computed from the list state
    typedef struct packed {
        logic   found;
        t_entry victim_id;
        logic   was_listed;
    } t_resp;

endpackage

// ===== rtl/lru_ot_list.sv =====
// List state (membership flags, link memories, head, tail, empty flag) and its update logic.
// Depends on lru_ot_pkg and lru_order_tracker_top_defines.svh.
module lru_ot_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_lookup_en,
    input  lru_ot_pkg::t_entry i_lookup_id,
    input  logic               i_req_vld,
    input  lru_ot_pkg::t_req   i_req,
    output lru_ot_pkg::t_resp  o_resp
);
    import lru_ot_pkg::*;
    `include "lru_order_tracker_top_defines.svh"

    // One link word: neighbour present flag and neighbour number
    typedef struct packed {
        logic   has;
        t_entry ptr;
    } t_link;

    // List state
    logic [ENTRIES-1:0] r_in_list;
    t_link              r_next_mem [ENTRIES];
    t_link              r_prev_mem [ENTRIES];
    t_link              r_rd_next;
    t_link              r_rd_prev;
    t_entry             r_head;
    t_entry             r_tail;
    logic               r_empty;

    t_entry             n_head;
    t_entry             n_tail;
    logic               n_empty;

    // Decoded request
    t_entry e_id;
    t_entry e_next;
    t_entry e_prev;
    logic   e_listed;
    logic   e_hn;
    logic   e_hp;
    logic   is_touch;
    logic   do_move;
    logic   do_remove;
    logic   do_unlink;

    // Link write ports: A = unlink neighbours, B = moved entry, C = old head
    logic   wn_a_en;
    logic   wn_b_en;
    logic   wp_a_en;
    logic   wp_b_en;
    logic   wp_c_en;
    t_link  wn_a_data;
    t_link  wn_b_data;
    t_link  wp_a_data;
    t_link  wp_b_data;
    t_link  wp_c_data;

    // Lookup address hit by a write completing on the same edge
    logic   fn_a_hit;
    logic   fn_b_hit;
    logic   fp_a_hit;
    logic   fp_b_hit;
    logic   fp_c_hit;

    logic   found;

    // Addressed entry; link words were read when the transaction was taken
    always_comb begin
        e_id     = i_req.entry_id;
        e_listed = r_in_list[e_id];
        e_hn     = r_rd_next.has;
        e_hp     = r_rd_prev.has;
        e_next   = r_rd_next.ptr;
        e_prev   = r_rd_prev.ptr;
    end

    // Action decode; a protected entry that is listed is moved to the head,
    // one that is not listed would be linked and unlinked again, a net no-op
    always_comb begin
        is_touch  = (i_req.action == ACT_TOUCH) ||
                    ((i_req.action == ACT_RECLAIM) && i_req.keep_given && e_listed);
        do_move   = is_touch && !(e_listed && !e_hp);
        do_remove = (i_req.action == ACT_REMOVE) && e_listed;
        do_unlink = (do_move && e_listed) || do_remove;

        wn_a_en   = do_unlink && e_hp;
        wp_a_en   = do_unlink && e_hn;
        wn_b_en   = do_move;
        wp_b_en   = do_move;
        wp_c_en   = do_move && !r_empty;
    end

    // Link write data
    always_comb begin
        wn_a_data.has = e_hn;
        wn_a_data.ptr = e_next;
        wn_b_data.has = !r_empty;
        wn_b_data.ptr = r_head;
        wp_a_data.has = e_hp;
        wp_a_data.ptr = e_prev;
        wp_b_data.has = 1'b0;
        wp_b_data.ptr = '0;
        wp_c_data.has = 1'b1;
        wp_c_data.ptr = e_id;
    end

    // Bypass hits for the lookup of the next transaction
    always_comb begin
        fn_a_hit = i_req_vld && wn_a_en && (e_prev == i_lookup_id);
        fn_b_hit = i_req_vld && wn_b_en && (e_id == i_lookup_id);
        fp_a_hit = i_req_vld && wp_a_en && (e_next == i_lookup_id);
        fp_b_hit = i_req_vld && wp_b_en && (e_id == i_lookup_id);
        fp_c_hit = i_req_vld && wp_c_en && (r_head == i_lookup_id);
    end

    // Head, tail and empty flag
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_empty = r_empty;
        unique case (i_req.action)
            ACT_TOUCH, ACT_RECLAIM: begin
                if (do_move) begin
                    n_head  = e_id;
                    n_empty = 1'b0;
                    if (e_listed && !e_hn) begin
                        n_tail = e_prev;
                    end else if (r_empty) begin
                        n_tail = e_id;
                    end
                end
            end
            ACT_REMOVE: begin
                if (do_remove) begin
                    if (!e_hn) begin
                        n_tail = e_hp ? e_prev : '0;
                    end
                    if (!e_hp) begin
                        n_head = e_hn ? e_next : '0;
                    end
                    if (!e_hn && !e_hp) begin
                        n_empty = 1'b1;
                    end
                end
            end
            ACT_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b1;
            end
            default: begin
                n_head  = r_head;
            end
        endcase
    end

    // Result: the tail after any move of the protected entry
    always_comb begin
        found             = (i_req.action == ACT_RECLAIM) && !n_empty &&
                            !(i_req.keep_given && (n_tail == e_id));
        o_resp.found      = found;
        o_resp.victim_id  = found ? n_tail : '0;
        o_resp.was_listed = e_listed;
    end

    // Control state: membership, head, tail, empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_list <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_empty   <= 1'b1;
        end else if (i_req_vld) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            if (i_req.action == ACT_CLEAR) begin
                r_in_list <= '0;
            end else if (do_move) begin
                r_in_list[e_id] <= 1'b1;
            end else if (do_remove) begin
                r_in_list[e_id] <= 1'b0;
            end
        end
    end

    // Link memory writes; ports never hit the same word in one cycle
    always_ff @(posedge i_clk) begin
        if (i_req_vld) begin
            if (wn_a_en) begin
                r_next_mem[e_prev] <= wn_a_data;
            end
            if (wn_b_en) begin
                r_next_mem[e_id] <= wn_b_data;
            end
            if (wp_a_en) begin
                r_prev_mem[e_next] <= wp_a_data;
            end
            if (wp_b_en) begin
                r_prev_mem[e_id] <= wp_b_data;
            end
            if (wp_c_en) begin
                r_prev_mem[r_head] <= wp_c_data;
            end
        end
    end

    // Registered link read at the accept edge, bypassing same-edge writes
    always_ff @(posedge i_clk) begin
        if (i_lookup_en) begin
            if (fn_b_hit) begin
                r_rd_next <= wn_b_data;
            end else if (fn_a_hit) begin
                r_rd_next <= wn_a_data;
            end else begin
                r_rd_next <= r_next_mem[i_lookup_id];
            end
            if (fp_c_hit) begin
                r_rd_prev <= wp_c_data;
            end else if (fp_b_hit) begin
                r_rd_prev <= wp_b_data;
            end else if (fp_a_hit) begin
                r_rd_prev <= wp_a_data;
            end else begin
                r_rd_prev <= r_prev_mem[i_lookup_id];
            end
        end
    end

    // Invariants of the list bookkeeping
    `LOT_ASSERT(a_empty_ptrs, r_empty |-> (r_head == '0 && r_tail == '0), "empty, ends set")
    `LOT_ASSERT(a_empty_members, r_empty == (r_in_list == '0), "empty flag mismatch")
    `LOT_ASSERT(a_ends_listed, !r_empty |-> r_in_list[r_head] && r_in_list[r_tail], "end unlisted")
    `LOT_ASSERT(a_clear_empties, i_req_vld && i_req.action == ACT_CLEAR |=> r_empty, "not cleared")

endmodule

// ===== rtl/lru_order_tracker_top.sv =====
// Top level of the LRU order tracker: input register, list core, result register.
// Depends on lru_ot_pkg and lru_ot_list.
//
// Usage
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is always low, so one command may be issued per cycle.
//   Fields: i_action (touch, remove, reclaim query, clear all), i_entry_id and
//   i_keep_given (protected-entry flag for reclaim).
//   Result channel: every command produces one result, shown on o_found,
//   o_victim_id and o_was_listed for exactly one cycle while o_done is high.
//   Path: a command passes the input register, then the list update into
//   the result register, which drives the result ports. Throughput: one
//   command per cycle; the entry's link words are read as the command is
//   taken, bypassing the update that completes on the same edge.
//   The receiver cannot stall; results must be taken when o_done is high.
//   Reset (synchronous, active low) empties the list and drops any command
//   in flight; link contents are not cleared and need not be.
module lru_order_tracker_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_action,
    input  lru_ot_pkg::t_entry  i_entry_id,
    input  logic                i_keep_given,
    output logic                o_done,
    output logic                o_found,
    output lru_ot_pkg::t_entry  o_victim_id,
    output logic                o_was_listed
);
    import lru_ot_pkg::*;

    logic  r_req_vld;
    t_req  r_req;
    logic  r_done;
    t_resp r_resp;
    t_resp core_resp;

    // Never back-pressured
    assign busy = 1'b0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req.action     <= t_action'(i_action);
            r_req.entry_id   <= i_entry_id;
            r_req.keep_given <= i_keep_given;
        end
    end

    lru_ot_list u_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lookup_en (start && !busy),
        .i_lookup_id (i_entry_id),
        .i_req_vld   (r_req_vld),
        .i_req       (r_req),
        .o_resp      (core_resp)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_resp <= core_resp;
        end
    end

    assign o_done       = r_done;
    assign o_found      = r_resp.found;
    assign o_victim_id  = r_resp.victim_id;
    assign o_was_listed = r_resp.was_listed;

endmodule
